FILE: hdl/depth_pixel_backprojection_defines.svh
// Assertion macros shared by the depth back-projection design.
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define DPB_ASSERT_IMP(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DPB_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: hdl/dpb_pkg.sv
// Package with the constants and types of the depth back-projection design.
`default_nettype none
package dpb_pkg;
	localparam int COORD_BITS_DEF = 12;
	localparam int DEPTH_BITS_DEF = 16;
	localparam int REG_BITS = 16;
	localparam int OUT_BITS = 24;
	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MIN_DIST = 3'd0,
		REG_MAX_DIST = 3'd1,
		REG_FOCAL_X  = 3'd2,
		REG_FOCAL_Y  = 3'd3,
		REG_CENTER_X = 3'd4,
		REG_CENTER_Y = 3'd5
	} cfg_idx_t;

	localparam logic signed [OUT_BITS-1:0] SAT_POS = {1'b0, {(OUT_BITS-1){1'b1}}};
	localparam logic signed [OUT_BITS-1:0] SAT_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};
endpackage
`default_nettype wire

FILE: hdl/dpb_divider.sv
// Pipelined restoring divider: one quotient bit per stage, with saturation.
`default_nettype none
module dpb_divider #(
	parameter int NUM_BITS = 40
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             advance,
	input  wire logic [NUM_BITS-1:0]              numerator,
	input  wire logic                             negative,
	input  wire logic [dpb_pkg::REG_BITS-1:0]     divisor,
	output logic signed [dpb_pkg::OUT_BITS-1:0]   quotient
);
	import dpb_pkg::*;

	// Stage k holds the partial remainder and the quotient bits found so far.
	logic [NUM_BITS-1:0]  num_q  [NUM_BITS+1];
	logic [REG_BITS:0]    rem_q  [NUM_BITS+1];
	logic [REG_BITS-1:0]  div_q  [NUM_BITS+1];
	logic                 neg_q  [NUM_BITS+1];
	logic                 zero_q [NUM_BITS+1];

	always_comb begin
		num_q[0]  = numerator;
		rem_q[0]  = '0;
		div_q[0]  = divisor;
		neg_q[0]  = negative;
		zero_q[0] = (numerator == '0);
	end

	for (genvar k = 0; k < NUM_BITS; k++) begin : g_step
		logic [REG_BITS:0]   trial;
		logic                fits;
		logic [NUM_BITS-1:0] nnum;
		always_comb begin
			trial = {rem_q[k][REG_BITS-1:0], num_q[k][NUM_BITS-1]};
			fits  = (trial >= {1'b0, div_q[k]});
			nnum  = {num_q[k][NUM_BITS-2:0], fits};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rem_q[k+1]  <= '0;
				num_q[k+1]  <= '0;
				div_q[k+1]  <= '0;
				neg_q[k+1]  <= 1'b0;
				zero_q[k+1] <= 1'b0;
			end else if (advance) begin
				rem_q[k+1]  <= fits ? (trial - {1'b0, div_q[k]}) : trial;
				num_q[k+1]  <= nnum;
				div_q[k+1]  <= div_q[k];
				neg_q[k+1]  <= neg_q[k];
				zero_q[k+1] <= zero_q[k];
			end
		end
	end

	// After all steps num holds the quotient; a zero divisor saturates.
	logic [NUM_BITS-1:0] q_fin;
	always_comb begin
		q_fin = num_q[NUM_BITS];
		if (zero_q[NUM_BITS]) begin
			quotient = '0;
		end else if (neg_q[NUM_BITS]) begin
			if (q_fin >= NUM_BITS'(64'd8388608)) quotient = SAT_NEG;
			else quotient = -$signed(q_fin[OUT_BITS-1:0]);
		end else begin
			if (q_fin > NUM_BITS'(64'd8388607)) quotient = SAT_POS;
			else quotient = $signed(q_fin[OUT_BITS-1:0]);
		end
	end
endmodule
`default_nettype wire

FILE: hdl/depth_pixel_backprojection.sv
// Top level of the depth pixel back-projection pipeline.
// Usage: one depth pixel beat enters on in_valid/in_ready with its column,
// row, depth and not-a-number flag; one point beat leaves on out_valid and
// out_ready carrying x, y and the depth that was used.
// Configuration beats on cfg_valid/cfg_ready write one of six 16-bit
// registers by index; they are taken at once and must only be sent while
// the pipeline is empty.
// Throughput is one pixel per cycle while the receiver is not stalling.
// Products are OFF_BITS + DEPTH_BITS bits wide, OFF_BITS being the larger
// of COORD_BITS + 4 and 16. One stage selects the depth, one forms the
// offset product, then the restoring divider resolves one quotient bit per
// stage, and the last stage is the output register.
// Every stage advances together whenever the output register is empty or
// being read, so a stalled receiver freezes the whole pipeline and no beat
// is lost or repeated; in_ready then falls.
// Reset clears all valid bits and loads the register defaults
// (minimum 100 mm, maximum 20000 mm, focal 8192, centre 5120 and 3840).
`default_nettype none
`include "depth_pixel_backprojection_defines.svh"
module depth_pixel_backprojection #(
	parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
	parameter int DEPTH_BITS = dpb_pkg::DEPTH_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [COORD_BITS-1:0]                column,
	input  wire logic [COORD_BITS-1:0]                row,
	input  wire logic [DEPTH_BITS-1:0]                depth_mm,
	input  wire logic                                 depth_not_number,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [dpb_pkg::OUT_BITS-1:0]       point_x_mm,
	output logic signed [dpb_pkg::OUT_BITS-1:0]       point_y_mm,
	output logic [DEPTH_BITS-1:0]                     point_z_mm,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [dpb_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  wire logic [dpb_pkg::REG_BITS-1:0]         cfg_data
);
	import dpb_pkg::*;

	// Offset magnitude needs up to COORD_BITS+4 bits, the centre REG_BITS bits.
	localparam int OFF_BITS = (COORD_BITS + 4 > REG_BITS) ? COORD_BITS + 4 : REG_BITS;
	localparam int NUM_BITS = OFF_BITS + DEPTH_BITS;
	localparam int LAT = NUM_BITS + 2;

	logic [REG_BITS-1:0] min_q, max_q, fx_q, fy_q, cx_q, cy_q;

	assign cfg_ready = 1'b1;

	// Configuration registers; indices beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 16'd100;
			max_q <= 16'd20000;
			fx_q  <= 16'd8192;
			fy_q  <= 16'd8192;
			cx_q  <= 16'd5120;
			cy_q  <= 16'd3840;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				REG_MIN_DIST: min_q <= cfg_data;
				REG_MAX_DIST: max_q <= cfg_data;
				REG_FOCAL_X:  fx_q  <= cfg_data;
				REG_FOCAL_Y:  fy_q  <= cfg_data;
				REG_CENTER_X: cx_q  <= cfg_data;
				REG_CENTER_Y: cy_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves as one when the output register can take a beat.
	logic advance;
	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	// Valid bits, one per stage; index LAT-1 feeds the output register.
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (advance) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Stage 1: pick the depth and form the signed pixel offsets.
	logic [DEPTH_BITS-1:0] dmin, dmax, dsel;
	logic signed [OFF_BITS:0] offx, offy;
	always_comb begin
		dmin = DEPTH_BITS'(min_q[DEPTH_BITS <= REG_BITS ? DEPTH_BITS-1 : REG_BITS-1:0]);
		dmax = DEPTH_BITS'(max_q[DEPTH_BITS <= REG_BITS ? DEPTH_BITS-1 : REG_BITS-1:0]);
		if (depth_not_number || depth_mm == '0 || depth_mm < dmin || depth_mm > dmax)
			dsel = dmax;
		else
			dsel = depth_mm;
		offx = $signed({1'b0, OFF_BITS'({column, 4'b0000})}) - $signed({1'b0, OFF_BITS'(cx_q)});
		offy = $signed({1'b0, OFF_BITS'({row, 4'b0000})}) - $signed({1'b0, OFF_BITS'(cy_q)});
	end

	logic [DEPTH_BITS-1:0] z_s1;
	logic [OFF_BITS-1:0]   magx_s1, magy_s1;
	logic                  negx_s1, negy_s1;
	always_ff @(posedge clk) begin
		if (advance) begin
			z_s1    <= dsel;
			negx_s1 <= offx[OFF_BITS];
			negy_s1 <= offy[OFF_BITS];
			magx_s1 <= offx[OFF_BITS] ? OFF_BITS'(-offx) : OFF_BITS'(offx);
			magy_s1 <= offy[OFF_BITS] ? OFF_BITS'(-offy) : OFF_BITS'(offy);
		end
	end

	// Stage 2: the two magnitude products.
	logic [NUM_BITS-1:0] numx_s2, numy_s2;
	logic                negx_s2, negy_s2;
	always_ff @(posedge clk) begin
		if (advance) begin
			numx_s2 <= NUM_BITS'(magx_s1) * NUM_BITS'(z_s1);
			numy_s2 <= NUM_BITS'(magy_s1) * NUM_BITS'(z_s1);
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
		end
	end

	// Depth rides alongside the divider stages.
	logic [DEPTH_BITS-1:0] zdly_q [LAT];
	always_ff @(posedge clk) begin
		if (advance) begin
			zdly_q[0] <= dsel;
			for (int i = 1; i < LAT; i++) zdly_q[i] <= zdly_q[i-1];
		end
	end

	logic signed [OUT_BITS-1:0] qx, qy;
	dpb_divider #(.NUM_BITS(NUM_BITS)) u_div_x (
		.clk(clk), .arst_n(arst_n), .advance(advance),
		.numerator(numx_s2), .negative(negx_s2), .divisor(fx_q), .quotient(qx)
	);
	dpb_divider #(.NUM_BITS(NUM_BITS)) u_div_y (
		.clk(clk), .arst_n(arst_n), .advance(advance),
		.numerator(numy_s2), .negative(negy_s2), .divisor(fy_q), .quotient(qy)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= vld_q[LAT-1];
		end
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			point_x_mm <= qx;
			point_y_mm <= qy;
			point_z_mm <= zdly_q[LAT-1];
		end
	end

	// A stalled result must stay valid and keep its depth until it is taken.
	`DPB_ASSERT_NEXT(a_hold_stall, clk, arst_n, out_valid && !out_ready, out_valid && $stable(point_z_mm))
	// The input side only opens when the output register can move.
	`DPB_ASSERT_IMP(a_ready_link, clk, arst_n, in_ready, !out_valid || out_ready)
	// An accepted beat sets the first valid bit of the pipeline.
	`DPB_ASSERT_NEXT(a_enter_tracked, clk, arst_n, in_valid && in_ready, vld_q[0])
endmodule
`default_nettype wire
